// ----- design/srfc_pkg.sv -----
package srfc_pkg;

    // Frame kinds held in the configuration register
    localparam logic [1:0] KIND_MEAS   = 2'd0;
    localparam logic [1:0] KIND_SERIAL = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // CRC-8 constants: polynomial x^8+x^5+x^4+1, all-ones preset
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Last byte position for each frame length
    localparam logic [2:0] LAST_POS_LONG  = 3'd5;
    localparam logic [2:0] LAST_POS_SHORT = 3'd2;

    // Scaling constants (hundredths)
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;
    localparam logic [15:0] FULL_SCALE  = 16'hFFFF;

    // Result codes
    localparam logic RESULT_OK      = 1'b0;
    localparam logic RESULT_CRC_ERR = 1'b1;

    // Assembled frame handed from the tracker to the scaler
    typedef struct packed {
        logic        crc_err;
        logic [1:0]  kind;
        logic [15:0] word_one;
        logic [15:0] word_two;
    } srfc_frame_t;

    // Finished result item
    typedef struct packed {
        logic               result_code;
        logic [15:0]        first_word;
        logic [15:0]        second_word;
        logic [31:0]        serial_number;
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
    } srfc_result_t;

    // One byte of CRC-8, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
        end
        return v;
    endfunction

endpackage

// ----- design/srfc_frame_tracker.sv -----
module srfc_frame_tracker
    import srfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        frame_kind,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  logic [7:0]        rx_byte,
    input  logic              frame_start,
    output logic              frame_valid,
    input  logic              frame_ready,
    output srfc_frame_t       frame
);

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] w1_reg, w1_next;
    logic [15:0] w2_reg, w2_next;
    logic        err_reg, err_next;
    logic        frame_valid_reg, frame_valid_next;
    srfc_frame_t frame_reg, frame_next;

    logic        accept;
    logic [2:0]  pos_cur;
    logic [7:0]  crc_cur;
    logic [15:0] w1_cur, w2_cur;
    logic        err_cur;
    logic [2:0]  last_pos;
    logic        is_last;
    logic [7:0]  crc_upd;
    logic [15:0] w1_upd, w2_upd;
    logic        err_upd;

    assign byte_ready  = !frame_valid_reg || frame_ready;
    assign accept      = byte_valid && byte_ready;
    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

    // Restart the frame on a start mark
    always_comb
    begin
        if (frame_start)
        begin
            pos_cur = '0;
            crc_cur = CRC_INIT;
            w1_cur  = '0;
            w2_cur  = '0;
            err_cur = 1'b0;
        end
        else
        begin
            pos_cur = (pos_reg > LAST_POS_LONG) ? 3'd0 : pos_reg;
            crc_cur = crc_reg;
            w1_cur  = w1_reg;
            w2_cur  = w2_reg;
            err_cur = err_reg;
        end
    end

    // Fold data bytes into the word and CRC, compare check bytes
    always_comb
    begin
        crc_upd = crc_cur;
        w1_upd  = w1_cur;
        w2_upd  = w2_cur;
        err_upd = err_cur;
        unique case (pos_cur)
            3'd0, 3'd1:
            begin
                crc_upd = crc8_byte(crc_cur, rx_byte);
                w1_upd  = {w1_cur[7:0], rx_byte};
            end
            3'd3, 3'd4:
            begin
                crc_upd = crc8_byte(crc_cur, rx_byte);
                w2_upd  = {w2_cur[7:0], rx_byte};
            end
            default:
            begin
                err_upd = err_cur || (rx_byte != crc_cur);
                crc_upd = CRC_INIT;
            end
        endcase
    end

    assign last_pos = (frame_kind == KIND_STATUS) ? LAST_POS_SHORT : LAST_POS_LONG;
    assign is_last  = pos_cur >= last_pos;

    // Advance position or hand off a finished frame
    always_comb
    begin
        pos_next         = pos_reg;
        crc_next         = crc_reg;
        w1_next          = w1_reg;
        w2_next          = w2_reg;
        err_next         = err_reg;
        frame_next       = frame_reg;
        frame_valid_next = frame_valid_reg && !frame_ready;
        if (accept)
        begin
            if (is_last)
            begin
                pos_next            = '0;
                crc_next            = CRC_INIT;
                w1_next             = '0;
                w2_next             = '0;
                err_next            = 1'b0;
                frame_valid_next    = 1'b1;
                frame_next.crc_err  = err_upd;
                frame_next.kind     = frame_kind;
                frame_next.word_one = w1_upd;
                frame_next.word_two = (frame_kind == KIND_STATUS) ? 16'd0 : w2_upd;
            end
            else
            begin
                pos_next = pos_cur + 3'd1;
                crc_next = crc_upd;
                w1_next  = w1_upd;
                w2_next  = w2_upd;
                err_next = err_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            crc_reg         <= CRC_INIT;
            w1_reg          <= '0;
            w2_reg          <= '0;
            err_reg         <= 1'b0;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            crc_reg         <= crc_next;
            w1_reg          <= w1_next;
            w2_reg          <= w2_next;
            err_reg         <= err_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS_LONG)
        else $error("byte position beyond frame end");

    a_crc_preset: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == 3'd0 || pos_reg == 3'd3) |-> crc_reg == CRC_INIT)
        else $error("CRC not preset at word boundary");

    a_last_hands_off: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_last) |=> frame_valid_reg)
        else $error("finished frame not handed off");

    a_mid_frame_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_last && !frame_valid_reg) |=> !frame_valid_reg)
        else $error("frame handed off before last byte");
`endif

endmodule

// ----- design/srfc_scaler.sv -----
module srfc_scaler
    import srfc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         frame_valid,
    output logic         frame_ready,
    input  srfc_frame_t  frame,
    output logic         result_valid,
    input  logic         result_ready,
    output srfc_result_t result
);

    logic         out_valid_reg, out_valid_next;
    srfc_result_t out_reg, out_next;

    logic [30:0]  t_prod;
    logic [29:0]  h_prod;
    logic [14:0]  t_q0, t_q;
    logic [13:0]  h_q0, h_q;
    logic [16:0]  t_rem, h_rem;
    logic [14:0]  t_diff;

    assign frame_ready  = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Scale raw words: product, then floor divide by 65535 via x>>16 plus one correction
    assign t_prod = 31'(frame.word_one) * 31'(TEMP_SPAN);
    assign h_prod = 30'(frame.word_two) * 30'(HUM_SPAN);
    assign t_q0   = t_prod[30:16];
    assign h_q0   = h_prod[29:16];
    assign t_rem  = 17'(t_prod[15:0]) + 17'(t_q0);
    assign h_rem  = 17'(h_prod[15:0]) + 17'(h_q0);
    assign t_q    = t_q0 + 15'(t_rem >= 17'(FULL_SCALE));
    assign h_q    = h_q0 + 14'(h_rem >= 17'(FULL_SCALE));
    assign t_diff = t_q - TEMP_OFFSET;

    // Build the result item for the frame kind
    always_comb
    begin
        out_next                   = out_reg;
        out_valid_next             = out_valid_reg && !result_ready;
        if (frame_valid && frame_ready)
        begin
            out_valid_next             = 1'b1;
            out_next.result_code       = frame.crc_err ? RESULT_CRC_ERR : RESULT_OK;
            out_next.first_word        = frame.word_one;
            out_next.second_word       = frame.word_two;
            out_next.serial_number     = '0;
            out_next.temperature_centi = '0;
            out_next.humidity_centi    = '0;
            priority if (frame.kind == KIND_SERIAL)
            begin
                out_next.serial_number = {frame.word_one, frame.word_two};
            end
            else if (frame.kind != KIND_STATUS)
            begin
                out_next.temperature_centi = $signed(t_diff);
                out_next.humidity_centi    = h_q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

`ifndef SYNTHESIS
    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.humidity_centi <= HUM_SPAN)
        else $error("humidity beyond full scale");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.temperature_centi >= -15'sd4500
                           && out_reg.temperature_centi <= 15'sd13000))
        else $error("temperature out of range");

    a_serial_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.serial_number != 32'd0)
            |-> (out_reg.humidity_centi == 14'd0 && out_reg.temperature_centi == 15'sd0))
        else $error("serial and measurement fields both set");
`endif

endmodule

// ----- design/sensor_response_frame_checker.sv -----
// Channel   Dir  Bits  Contents
// s_*       in   8+1   tdata: rx_byte; tuser: frame_start
// m_*       out  96+1  tdata: words, serial, temperature, humidity; tuser: result_code
// cfg_*     in   2     frame_kind write, no read-back
//
// One byte item per cycle while s_tready is high; after the last byte of a frame,
// the result item passes the frame register, then the scaling and result register.
// Reset clears position, words, error flag, presets CRC, frame_kind to measurement.
// A stall on m_* fills the result register, then the frame register, then drops s_tready.
module sensor_response_frame_checker
    import srfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic        s_tuser,    // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,    // [15:0] first_word, [31:16] second_word,
                                    // [63:32] serial_number, [78:64] temperature_centi,
                                    // [92:79] humidity_centi, [95:93] zero
    output logic        m_tuser     // [0] result_code
);

    logic [1:0]   frame_kind_reg;
    logic         frame_valid;
    logic         frame_ready;
    srfc_frame_t  frame;
    srfc_result_t result;

    // Hold the frame kind register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_kind_reg <= KIND_MEAS;
        end
        else if (cfg_we)
        begin
            frame_kind_reg <= cfg_wdata;
        end
    end

    srfc_frame_tracker u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_kind  (frame_kind_reg),
        .byte_valid  (s_tvalid),
        .byte_ready  (s_tready),
        .rx_byte     (s_tdata),
        .frame_start (s_tuser),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    srfc_scaler u_scaler (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .frame        (frame),
        .result_valid (m_tvalid),
        .result_ready (m_tready),
        .result       (result)
    );

    // Pack the result item onto the stream
    assign m_tdata = {3'b000, result.humidity_centi, result.temperature_centi,
                      result.serial_number, result.second_word, result.first_word};
    assign m_tuser = result.result_code;

endmodule
